@@ rtl/hb_pkg.sv @@
// shared constants and types for the binary heap builder
`timescale 1ns / 1ps

package hb_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;

  // configuration register indexes
  localparam logic REG_HEAP_ORDER   = 1'b0;
  localparam logic REG_BUILD_METHOD = 1'b1;

  // request to the shared compare unit: does a rank above b
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     min_heap;
  } cmp_req_t;

endpackage

@@ rtl/hb_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module hb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hb_cmp.sv @@
// shared strict compare unit for max-heap or min-heap ordering
`timescale 1ns / 1ps

module hb_cmp (
  input  hb_pkg::cmp_req_t req,
  output logic             above
);

  always_comb begin
    if (req.min_heap) begin
      above = $signed(req.a) < $signed(req.b);
    end else begin
      above = $signed(req.a) > $signed(req.b);
    end
  end

endmodule

@@ rtl/binary_heap_builder_core.sv @@
// binary heap builder: load, in-place heap build, in-order emission
//
//   channel  | handshake             | word
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_ready   | element_value, last_item
//   output   | out_valid / out_ready | heap_value, final_result, overflow_seen
//   config   | cfg_we                | cfg_index, cfg_data
//
// loading accepts one word per cycle; the build starts on the word marked last.
// build speed is bound by the element ram (one read, one write port) and the one
// compare unit: insertion raises each element level by level, sift-down
// sinks each middle node comparing both children, emission reads each result
// and waits for a free output register. in_ready is low from the last word until
// the final result is in the output register. reset clears counts and state.
`timescale 1ns / 1ps

module binary_heap_builder_core #(
  parameter int CAPACITY = hb_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [0:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [hb_pkg::DATA_W-1:0] element_value,
  input  logic                            last_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [hb_pkg::DATA_W-1:0] heap_value,
  output logic                            final_result,
  output logic                            overflow_seen
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    LOAD, INS_NEXT, INS_GET, INS_STEP, INS_CMP,
    SFT_NEXT, SFT_GET, SFT_STEP, SFT_CMPL, SFT_CMPR, SFT_END,
    EMIT_RD, EMIT_PUT
  } state_t;

  state_t state;

  logic                      heap_order;
  logic                      build_method;
  logic                      min_heap;
  logic [CW-1:0]             elem_count;
  logic                      dropped;
  logic [CW-1:0]             n_items;
  logic                      ovf_load;
  logic [CW-1:0]             idx;
  logic [AW-1:0]             pos;
  logic [AW-1:0]             up;
  logic [AW-1:0]             bpos;
  logic                      moved;
  logic [hb_pkg::DATA_W-1:0] cur;
  logic [hb_pkg::DATA_W-1:0] bval;

  logic                      in_fire;
  logic                      has_room;
  logic [CW-1:0]             count_next;
  logic [CW-1:0]             idx_dec;
  logic [AW-1:0]             parent;
  logic [XW-1:0]             left_x;
  logic [XW-1:0]             right_x;
  logic [XW-1:0]             n_x;
  logic                      left_in;
  logic                      right_in;
  logic                      out_free;
  logic                      emit_last;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [hb_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [hb_pkg::DATA_W-1:0] ram_rdata;

  hb_pkg::cmp_req_t          cmp_req;
  logic                      cmp_above;

  assign in_ready   = (state == LOAD);
  assign in_fire    = in_valid && in_ready;
  assign has_room   = (elem_count < CAP_C);
  assign count_next = has_room ? elem_count + CW'(1) : elem_count;
  assign idx_dec    = idx - CW'(1);
  assign parent     = (pos - AW'(1)) >> 1;
  assign left_x     = (XW'(pos) << 1) | XW'(1);
  assign right_x    = left_x + XW'(1);
  assign n_x        = XW'(n_items);
  assign left_in    = (left_x < n_x);
  assign right_in   = (right_x < n_x);
  assign out_free   = !out_valid || out_ready;
  assign emit_last  = (idx + CW'(1) == n_items);

  hb_ram #(
    .WIDTH (hb_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hb_cmp u_cmp (
    .req   (cmp_req),
    .above (cmp_above)
  );

  // compare operand selection
  always_comb begin
    cmp_req.min_heap = min_heap;
    cmp_req.a        = cur;
    cmp_req.b        = ram_rdata;
    case (state)
      SFT_CMPL: begin
        cmp_req.a = ram_rdata;
        cmp_req.b = cur;
      end
      SFT_CMPR: begin
        cmp_req.a = ram_rdata;
        cmp_req.b = bval;
      end
      default: begin
        cmp_req.a = cur;
        cmp_req.b = ram_rdata;
      end
    endcase
  end

  // ram read address
  always_comb begin
    case (state)
      INS_NEXT: ram_raddr = idx[AW-1:0];
      INS_STEP: ram_raddr = parent;
      SFT_NEXT: ram_raddr = idx_dec[AW-1:0];
      SFT_STEP: ram_raddr = left_x[AW-1:0];
      SFT_CMPL: ram_raddr = right_x[AW-1:0];
      EMIT_RD:  ram_raddr = idx[AW-1:0];
      EMIT_PUT: ram_raddr = idx[AW-1:0];
      default:  ram_raddr = '0;
    endcase
  end

  // ram write port; moves use a hole that carries the element being placed
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur;
    case (state)
      LOAD: begin
        ram_we    = in_fire && has_room;
        ram_waddr = elem_count[AW-1:0];
        ram_wdata = element_value;
      end
      INS_STEP: begin
        ram_we = (pos == '0);
      end
      INS_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = cmp_above ? ram_rdata : cur;
      end
      SFT_STEP: begin
        ram_we = !left_in;
      end
      SFT_END: begin
        ram_we    = 1'b1;
        ram_wdata = moved ? bval : cur;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      heap_order   <= 1'b0;
      build_method <= 1'b0;
      min_heap     <= 1'b0;
      elem_count   <= '0;
      dropped      <= 1'b0;
      n_items      <= '0;
      ovf_load     <= 1'b0;
      idx          <= '0;
      pos          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hb_pkg::REG_HEAP_ORDER:   heap_order   <= cfg_data[0];
          hb_pkg::REG_BUILD_METHOD: build_method <= cfg_data[0];
          default: ;
        endcase
      end

      // in the put state the output register is reloaded below instead
      if (out_valid && out_ready && state != EMIT_PUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        LOAD: begin
          if (in_fire) begin
            if (last_item) begin
              n_items    <= count_next;
              ovf_load   <= dropped || !has_room;
              min_heap   <= heap_order;
              elem_count <= '0;
              dropped    <= 1'b0;
              if (build_method) begin
                idx   <= count_next >> 1;
                state <= SFT_NEXT;
              end else begin
                idx   <= CW'(1);
                state <= INS_NEXT;
              end
            end else begin
              elem_count <= count_next;
              dropped    <= dropped || !has_room;
            end
          end
        end

        INS_NEXT: begin
          if (idx >= n_items) begin
            idx   <= '0;
            state <= EMIT_RD;
          end else begin
            state <= INS_GET;
          end
        end

        INS_GET: begin
          cur   <= ram_rdata;
          pos   <= idx[AW-1:0];
          state <= INS_STEP;
        end

        INS_STEP: begin
          if (pos == '0) begin
            idx   <= idx + CW'(1);
            state <= INS_NEXT;
          end else begin
            up    <= parent;
            state <= INS_CMP;
          end
        end

        INS_CMP: begin
          if (cmp_above) begin
            pos   <= up;
            state <= INS_STEP;
          end else begin
            idx   <= idx + CW'(1);
            state <= INS_NEXT;
          end
        end

        SFT_NEXT: begin
          if (idx == '0) begin
            state <= EMIT_RD;
          end else begin
            idx   <= idx_dec;
            pos   <= idx_dec[AW-1:0];
            state <= SFT_GET;
          end
        end

        SFT_GET: begin
          cur   <= ram_rdata;
          state <= SFT_STEP;
        end

        SFT_STEP: begin
          if (left_in) begin
            state <= SFT_CMPL;
          end else begin
            state <= SFT_NEXT;
          end
        end

        SFT_CMPL: begin
          bval  <= cmp_above ? ram_rdata : cur;
          bpos  <= left_x[AW-1:0];
          moved <= cmp_above;
          state <= right_in ? SFT_CMPR : SFT_END;
        end

        SFT_CMPR: begin
          if (cmp_above) begin
            bval  <= ram_rdata;
            bpos  <= right_x[AW-1:0];
            moved <= 1'b1;
          end
          state <= SFT_END;
        end

        SFT_END: begin
          if (moved) begin
            pos   <= bpos;
            state <= SFT_STEP;
          end else begin
            state <= SFT_NEXT;
          end
        end

        EMIT_RD: begin
          state <= EMIT_PUT;
        end

        EMIT_PUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            heap_value    <= ram_rdata;
            final_result  <= emit_last;
            overflow_seen <= ovf_load;
            idx           <= idx + CW'(1);
            state         <= emit_last ? LOAD : EMIT_RD;
          end
        end

        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // the count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CAP_C)
    else $error("element count beyond capacity");

  // a drop only happens once the store is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> elem_count == CAP_C)
    else $error("drop flagged with room left");

  // a stored word that is not last advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_item && has_room |=> elem_count == $past(elem_count) + CW'(1))
    else $error("count did not advance on store");

endmodule

@@ tb/heap_build_checker.sv @@
// checker for the binary heap builder: predicts each heap and compares the output words
`timescale 1ns / 1ps

module heap_build_checker #(
  parameter int CAPACITY = hb_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [0:0]                       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [hb_pkg::DATA_W-1:0] element_value,
  input  logic                             last_item,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [hb_pkg::DATA_W-1:0] heap_value,
  input  logic                             final_result,
  input  logic                             overflow_seen,
  output int                               mismatches,
  output int                               pending_words,
  output int                               heaps_built,
  output int                               overflow_loads,
  output int                               words_checked
);

  typedef struct {
    logic signed [hb_pkg::DATA_W-1:0] value;
    logic                             last;
    logic                             ovf;
  } heap_word_t;

  heap_word_t expected_heap[$];

  logic signed [hb_pkg::DATA_W-1:0] elems [CAPACITY];
  int  fill;
  bit  dropped;
  bit  min_heap;
  bit  sift_build;
  int  err_count;
  int  built_count;
  int  ovf_count;
  int  seen_count;

  function automatic bit ranks_above(input logic signed [hb_pkg::DATA_W-1:0] a,
                                     input logic signed [hb_pkg::DATA_W-1:0] b);
    return min_heap ? (a < b) : (a > b);
  endfunction

  function automatic void swap_slots(input int i, input int j);
    logic signed [hb_pkg::DATA_W-1:0] t;
    t = elems[i];
    elems[i] = elems[j];
    elems[j] = t;
  endfunction

  // slots are 0-based here: children of p are 2p+1 and 2p+2
  function automatic void sift_down(input int start, input int n);
    int pos, left, right, best;
    pos = start;
    while (1) begin
      left = 2 * pos + 1;
      right = left + 1;
      best = pos;
      if (left < n && ranks_above(elems[left], elems[best])) best = left;
      if (right < n && ranks_above(elems[right], elems[best])) best = right;
      if (best == pos) return;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic void build_by_insertion(input int n);
    int pos, up;
    for (int i = 1; i < n; i++) begin
      pos = i;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!ranks_above(elems[pos], elems[up])) break;
        swap_slots(pos, up);
        pos = up;
      end
    end
  endfunction

  function automatic void build_by_sifting(input int n);
    for (int i = n / 2 - 1; i >= 0; i--) sift_down(i, n);
  endfunction

  always @(posedge clk) begin : watch
    heap_word_t want;
    if (rst) begin
      fill = 0;
      dropped = 0;
      min_heap = 0;
      sift_build = 0;
      expected_heap.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hb_pkg::REG_HEAP_ORDER:   min_heap = cfg_data[0];
          hb_pkg::REG_BUILD_METHOD: sift_build = cfg_data[0];
          default: ;
        endcase
      end
      // outputs first: a word leaving now belongs to an older heap
      if (out_valid && out_ready) begin
        seen_count++;
        if (expected_heap.size() == 0) begin
          $error("unexpected heap word: value %0d final %0b overflow %0b",
                 heap_value, final_result, overflow_seen);
          err_count++;
        end else begin
          want = expected_heap.pop_front();
          if (heap_value !== want.value) begin
            $error("heap_value mismatch: expected %0d, got %0d", want.value, heap_value);
            err_count++;
          end
          if (final_result !== want.last) begin
            $error("final_result mismatch: expected %0b, got %0b", want.last, final_result);
            err_count++;
          end
          if (overflow_seen !== want.ovf) begin
            $error("overflow_seen mismatch: expected %0b, got %0b", want.ovf, overflow_seen);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (fill < CAPACITY) begin
          elems[fill] = element_value;
          fill++;
        end else begin
          dropped = 1;
        end
        if (last_item) begin
          if (sift_build) build_by_sifting(fill);
          else build_by_insertion(fill);
          for (int k = 0; k < fill; k++) begin
            want.value = elems[k];
            want.last = (k == fill - 1);
            want.ovf = dropped;
            expected_heap.push_back(want);
          end
          built_count++;
          if (dropped) ovf_count++;
          fill = 0;
          dropped = 0;
        end
      end
    end
    pending_words  <= expected_heap.size();
    mismatches     <= err_count;
    heaps_built    <= built_count;
    overflow_loads <= ovf_count;
    words_checked  <= seen_count;
  end

endmodule

@@ tb/tb_top.sv @@
// top of the binary heap builder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP          = hb_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 2000;
  localparam int SETTLE       = 50;
  localparam int QUIET_LIMIT  = 20000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = 1'b0;
  logic [0:0]                       cfg_data = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [hb_pkg::DATA_W-1:0] element_value = '0;
  logic                             last_item = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [hb_pkg::DATA_W-1:0] heap_value;
  logic                             final_result;
  logic                             overflow_seen;

  int mismatches, pending_words, heaps_built, overflow_loads, words_checked;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_kicks = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  binary_heap_builder_core #(.CAPACITY(CAP)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .element_value, .last_item,
    .out_valid, .out_ready, .heap_value, .final_result, .overflow_seen
  );

  heap_build_checker #(.CAPACITY(CAP)) u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .element_value, .last_item,
    .out_valid, .out_ready, .heap_value, .final_result, .overflow_seen,
    .mismatches, .pending_words, .heaps_built, .overflow_loads, .words_checked
  );

  // receiver: random stalls, plus a long hold-off when kicked
  always @(posedge clk) begin : receiver
    int hold_left;
    int kicks_seen;
    if (hold_kicks != kicks_seen) begin
      kicks_seen = hold_kicks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("binary_heap_builder_core verification failed");
        $finish;
      end
    end
  end

  function automatic logic signed [hb_pkg::DATA_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      5, 6:    return int'($urandom_range(0, 8)) - 4;
      7:       return 32'sh7fff_ffff;
      8:       return 32'sh8000_0000;
      9:       return ($urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh0)
                      ^ $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // valid is only lowered when a gap is taken, so it never toggles within a step
  task automatic offer_word(input logic signed [hb_pkg::DATA_W-1:0] v, input logic last);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element_value <= v;
    last_item <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_load(input int n);
    for (int k = 0; k < n; k++) offer_word(rand_element(), k == n - 1);
  endtask

  // pause the sender until every heap word is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic order, input logic method);
    cfg_we <= 1'b1;
    cfg_index <= hb_pkg::REG_HEAP_ORDER;
    cfg_data <= order;
    @(posedge clk);
    cfg_index <= hb_pkg::REG_BUILD_METHOD;
    cfg_data <= method;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  function automatic int rand_load_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 12);
    if (pick < 82) return $urandom_range(13, CAP - 1);
    if (pick < 90) return CAP;
    return CAP + $urandom_range(1, 8);
  endfunction

  initial begin : stimulus
    logic signed [hb_pkg::DATA_W-1:0] pattern [6];
    int random_start;
    int phase;
    pattern = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, -32'sd1};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and a duplicate under every order/method setting
    for (int c = 0; c < 4; c++) begin
      drain();
      set_config(c[0], c[1]);
      set_idle_mode(c);
      for (int k = 0; k < 6; k++) offer_word(pattern[(k + c) % 6], k == 5);
    end
    // single-word heap
    offer_word(32'sh8000_0000, 1'b1);

    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      set_config($urandom_range(0, 1), $urandom_range(0, 1));
      set_idle_mode(phase);
      if (phase == 0) begin
        // receiver holds off while a full load and the next one are offered
        hold_kicks++;
        send_load(CAP);
        send_load(8);
      end
      repeat ($urandom_range(2, 4)) send_load(rand_load_size());
      phase++;
    end

    drain();
    $display("run summary: %0d heaps built, %0d of them with dropped words, %0d words checked",
             heaps_built, overflow_loads, words_checked);
    $display("  all order/method settings, loads from one word up to past capacity, %0d phases",
             phase);
    if (pending_words != 0)
      $error("%0d heap words still outstanding at the end", pending_words);
    if (mismatches == 0 && pending_words == 0) begin
      $display("binary_heap_builder_core verification clean");
    end else begin
      $display("binary_heap_builder_core verification failed");
    end
    $finish;
  end

endmodule

@@ binary_heap_builder_core.f @@
rtl/hb_pkg.sv
rtl/hb_ram.sv
rtl/hb_cmp.sv
rtl/binary_heap_builder_core.sv
tb/heap_build_checker.sv
tb/tb_top.sv
